FILE: sv/gds_pkg.sv
package gds_pkg;

	// Field widths
	localparam int unsigned YEAR_W  = 14;
	localparam int unsigned MONTH_W = 4;
	localparam int unsigned DAY_W   = 5;
	localparam int unsigned KIND_W  = 3;
	localparam int unsigned CMP_W   = 2;

	// Calendar limits
	localparam logic [YEAR_W-1:0]  YEAR_MIN   = 14'd1;
	localparam logic [YEAR_W-1:0]  YEAR_MAX   = 14'd9999;
	localparam logic [MONTH_W-1:0] MONTH_JAN  = 4'd1;
	localparam logic [MONTH_W-1:0] MONTH_DEC  = 4'd12;
	localparam logic [DAY_W-1:0]   DAY_FIRST  = 5'd1;
	localparam logic [DAY_W-1:0]   DAY_LONG   = 5'd31;

	// Divisibility by 25 on a 14-bit year: multiply by the inverse of 25 modulo 2^14,
	// the year is a multiple of 25 exactly when the low bits stay at or below 16383/25.
	localparam logic [YEAR_W-1:0] INV25     = 14'd7209;
	localparam logic [YEAR_W-1:0] DIV25_LIM = 14'd655;

	// Item kinds
	typedef enum logic [KIND_W-1:0] {
		KIND_SET        = 3'd0,
		KIND_NEXT_DAY   = 3'd1,
		KIND_PREV_DAY   = 3'd2,
		KIND_NEXT_MONTH = 3'd3,
		KIND_PREV_MONTH = 3'd4,
		KIND_COMPARE    = 3'd5
	} kind_t;

	// Compare outcomes
	localparam logic [CMP_W-1:0] CMP_LESS    = 2'd0;
	localparam logic [CMP_W-1:0] CMP_EQUAL   = 2'd1;
	localparam logic [CMP_W-1:0] CMP_GREATER = 2'd2;

	// One result word
	typedef struct packed {
		logic [YEAR_W-1:0]  year;
		logic [MONTH_W-1:0] month;
		logic [DAY_W-1:0]   day;
		logic               date_valid;
		logic [CMP_W-1:0]   cmp;
		logic               range_error;
	} gds_res_t;

	// Leap year: divisible by 4 and not by 100, or by 400 (400 = 16 * 25)
	function automatic logic leap_year(input logic [YEAR_W-1:0] y);
		logic [YEAR_W-1:0] prod;
		logic              div25;
		// only the product modulo 2^14 matters
		prod  = y * INV25;
		div25 = (prod <= DIV25_LIM);
		return (y[1:0] == 2'd0) && (!div25 || (y[3:0] == 4'd0));
	endfunction

	// Month length, zero for a month outside January to December
	function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
	                                                input logic leap);
		logic [DAY_W-1:0] len;
		unique case (m)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
			4'd2:                                       len = leap ? 5'd29 : 5'd28;
			default:                                    len = 5'd0;
		endcase
		return len;
	endfunction

endpackage

FILE: sv/gds_step.sv
module gds_step import gds_pkg::*; (
	input  logic [KIND_W-1:0]  kind,
	input  logic [YEAR_W-1:0]  in_year,
	input  logic [MONTH_W-1:0] in_month,
	input  logic [DAY_W-1:0]   in_day,
	input  logic [YEAR_W-1:0]  cur_year,
	input  logic [MONTH_W-1:0] cur_month,
	input  logic [DAY_W-1:0]   cur_day,
	output gds_res_t           res
);

	kind_t              kind_e;
	logic [DAY_W-1:0]   len_cur;
	logic [MONTH_W-1:0] month_up;
	logic [MONTH_W-1:0] month_dn;
	logic               carry_up;
	logic               borrow_dn;
	logic [YEAR_W:0]    year_inc;
	logic [YEAR_W-1:0]  year_dec;
	logic               inc_bad;
	logic               dec_bad;
	logic [DAY_W:0]     day_inc;
	logic [DAY_W-1:0]   len_dn;
	logic [YEAR_W-1:0]  nyear;
	logic [MONTH_W-1:0] nmonth;
	logic [DAY_W-1:0]   nday;
	logic               year_up;
	logic               year_dn;
	logic               err;
	logic [CMP_W-1:0]   cmp;
	logic [YEAR_W+MONTH_W+DAY_W-1:0] cur_key;
	logic [YEAR_W+MONTH_W+DAY_W-1:0] in_key;
	logic [YEAR_W-1:0]  ryear;
	logic [MONTH_W-1:0] rmonth;
	logic [DAY_W-1:0]   rday;
	logic [DAY_W-1:0]   len_new;

	assign kind_e = kind_t'(kind);

	// Month and year neighbours of the stored date
	always_comb begin
		len_cur   = month_days(cur_month, leap_year(cur_year));
		carry_up  = (cur_month >= MONTH_DEC);
		month_up  = carry_up ? MONTH_JAN : cur_month + 4'd1;
		borrow_dn = (cur_month <= MONTH_JAN);
		month_dn  = borrow_dn ? MONTH_DEC : cur_month - 4'd1;
		year_inc  = {1'b0, cur_year} + 15'd1;
		year_dec  = cur_year - 14'd1;
		inc_bad   = (year_inc > {1'b0, YEAR_MAX});
		dec_bad   = (cur_year <= YEAR_MIN) || (cur_year > YEAR_MAX + 14'd1);
		day_inc   = {1'b0, cur_day} + 6'd1;
		// no year borrow reaches February, so the stored year decides its length
		len_dn    = month_days(month_dn, leap_year(cur_year));
	end

	// Step the date for the item's kind
	always_comb begin
		nyear   = cur_year;
		nmonth  = cur_month;
		nday    = cur_day;
		year_up = 1'b0;
		year_dn = 1'b0;
		unique case (kind_e)
			KIND_SET: begin
				nyear  = in_year;
				nmonth = in_month;
				nday   = in_day;
			end
			KIND_NEXT_DAY: begin
				if (day_inc > {1'b0, len_cur}) begin
					nday    = DAY_FIRST;
					nmonth  = month_up;
					year_up = carry_up;
				end else begin
					nday = day_inc[DAY_W-1:0];
				end
			end
			KIND_PREV_DAY: begin
				if (cur_day <= DAY_FIRST) begin
					nmonth  = month_dn;
					year_dn = borrow_dn;
					nday    = (len_dn == 5'd0) ? DAY_LONG : len_dn;
				end else begin
					nday = cur_day - 5'd1;
				end
			end
			KIND_NEXT_MONTH: begin
				nmonth  = month_up;
				year_up = carry_up;
			end
			KIND_PREV_MONTH: begin
				nmonth  = month_dn;
				year_dn = borrow_dn;
			end
			default: begin
			end
		endcase
		if (year_up) begin
			nyear = year_inc[YEAR_W-1:0];
		end else if (year_dn) begin
			nyear = year_dec;
		end
	end

	// Hold the date when the year would leave its range
	assign err = (year_up && inc_bad) || (year_dn && dec_bad);

	always_comb begin
		if (err) begin
			ryear  = cur_year;
			rmonth = cur_month;
			rday   = cur_day;
		end else begin
			ryear  = nyear;
			rmonth = nmonth;
			rday   = nday;
		end
	end

	// Compare the stored date with the given one, year first
	assign cur_key = {cur_year, cur_month, cur_day};
	assign in_key  = {in_year, in_month, in_day};

	always_comb begin
		cmp = CMP_EQUAL;
		if (kind_e == KIND_COMPARE) begin
			if (cur_key < in_key) begin
				cmp = CMP_LESS;
			end else if (cur_key > in_key) begin
				cmp = CMP_GREATER;
			end
		end
	end

	// Assemble the result word
	assign len_new = month_days(rmonth, leap_year(ryear));

	always_comb begin
		res.year        = ryear;
		res.month       = rmonth;
		res.day         = rday;
		res.date_valid  = (rday >= DAY_FIRST) && (rday <= len_new);
		res.cmp         = cmp;
		res.range_error = err;
	end

endmodule

FILE: sv/gregorian_date_stepper_top.sv
// Channel  Handshake              Word
// input    in_valid / in_ready    kind, in_year, in_month, in_day
// output   out_valid / out_ready  out_year, out_month, out_day, date_valid,
//                                 compare_result, range_error
//
// One word per cycle while the output is not stalled: a taken word sits in the input
// register, where the date is stepped, and its result is written into the output
// register as the word moves on. The stored date updates as each result is
// written, so back-to-back words see every earlier step.
// Reset clears both registers to empty and loads the date 1-1-1.
// A stalled output holds its result; the input register still takes a new word
// while it is empty or moving on in the same cycle.
module gregorian_date_stepper_top import gds_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [KIND_W-1:0]  kind,
	input  logic [YEAR_W-1:0]  in_year,
	input  logic [MONTH_W-1:0] in_month,
	input  logic [DAY_W-1:0]   in_day,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [YEAR_W-1:0]  out_year,
	output logic [MONTH_W-1:0] out_month,
	output logic [DAY_W-1:0]   out_day,
	output logic               date_valid,
	output logic [CMP_W-1:0]   compare_result,
	output logic               range_error
);

	logic               valid_s1;
	logic [KIND_W-1:0]  kind_s1;
	logic [YEAR_W-1:0]  year_s1;
	logic [MONTH_W-1:0] month_s1;
	logic [DAY_W-1:0]   day_s1;
	logic [YEAR_W-1:0]  cur_year_q;
	logic [MONTH_W-1:0] cur_month_q;
	logic [DAY_W-1:0]   cur_day_q;
	logic               out_valid_q;
	gds_res_t           res_q;
	gds_res_t           res_d;
	logic               advance;
	logic               take;

	// Move a word on when the output register is free or being emptied
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;
	assign take     = in_valid && in_ready;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			kind_s1  <= kind;
			year_s1  <= in_year;
			month_s1 <= in_month;
			day_s1   <= in_day;
		end
	end

	// Step logic
	gds_step u_step (
		.kind      (kind_s1),
		.in_year   (year_s1),
		.in_month  (month_s1),
		.in_day    (day_s1),
		.cur_year  (cur_year_q),
		.cur_month (cur_month_q),
		.cur_day   (cur_day_q),
		.res       (res_d)
	);

	// Stored date
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_year_q  <= YEAR_MIN;
			cur_month_q <= MONTH_JAN;
			cur_day_q   <= DAY_FIRST;
		end else if (advance) begin
			cur_year_q  <= res_d.year;
			cur_month_q <= res_d.month;
			cur_day_q   <= res_d.day;
		end
	end

	// Output register: hold while stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_d;
		end
	end

	assign out_valid      = out_valid_q;
	assign out_year       = res_q.year;
	assign out_month      = res_q.month;
	assign out_day        = res_q.day;
	assign date_valid     = res_q.date_valid;
	assign compare_result = res_q.cmp;
	assign range_error    = res_q.range_error;

endmodule

FILE: verif/tb_gregorian_date_stepper_top.sv
module tb_gregorian_date_stepper_top;
	import gds_pkg::*;

	// Kinds the block must ignore
	localparam logic [KIND_W-1:0] KIND_SPARE_A = 3'd6;
	localparam logic [KIND_W-1:0] KIND_SPARE_B = 3'd7;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int RANDOM_WORDS = 910;
	localparam int DRAIN_CYCLES = 8;

	typedef struct {
		logic [KIND_W-1:0]  kind;
		logic [YEAR_W-1:0]  year;
		logic [MONTH_W-1:0] month;
		logic [DAY_W-1:0]   day;
	} date_word_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [KIND_W-1:0]  kind = '0;
	logic [YEAR_W-1:0]  in_year = '0;
	logic [MONTH_W-1:0] in_month = '0;
	logic [DAY_W-1:0]   in_day = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [YEAR_W-1:0]  out_year;
	logic [MONTH_W-1:0] out_month;
	logic [DAY_W-1:0]   out_day;
	logic               date_valid;
	logic [CMP_W-1:0]   compare_result;
	logic               range_error;

	gregorian_date_stepper_top dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.kind           (kind),
		.in_year        (in_year),
		.in_month       (in_month),
		.in_day         (in_day),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.out_year       (out_year),
		.out_month      (out_month),
		.out_day        (out_day),
		.date_valid     (date_valid),
		.compare_result (compare_result),
		.range_error    (range_error)
	);

	// Stored date as the block should hold it
	logic [YEAR_W-1:0]  cal_year  = 14'd1;
	logic [MONTH_W-1:0] cal_month = 4'd1;
	logic [DAY_W-1:0]   cal_day   = 5'd1;

	date_word_t pending_words[$];
	gds_res_t   dates_due[$];
	int         words_total = 0;
	int         words_taken = 0;
	int         cycles = 0;
	bit         failed_any = 1'b0;

	int burst_left = 0;
	int gap_left = 0;
	int stall_mode = 0;
	int mode_left = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	// Days in a month, zero for a month outside January to December
	function automatic int month_length(input int m, input int y);
		int ay;
		ay = (y < 0) ? -y : y;
		case (m)
			1, 3, 5, 7, 8, 10, 12: return 31;
			4, 6, 9, 11:           return 30;
			2: return (((ay % 4 == 0) && (ay % 100 != 0)) || (ay % 400 == 0)) ? 29 : 28;
			default:               return 0;
		endcase
	endfunction

	task automatic roll_month_fwd(inout int m, inout int y);
		m++;
		if (m > int'(MONTH_DEC)) begin
			m = int'(MONTH_JAN);
			y++;
		end
	endtask

	task automatic roll_month_back(inout int m, inout int y);
		m--;
		if (m < int'(MONTH_JAN)) begin
			m = int'(MONTH_DEC);
			y--;
		end
	endtask

	// Apply one word to the stored date and queue the result it should give
	task automatic advance_calendar(input date_word_t w);
		int               y, m, d, len;
		logic [CMP_W-1:0] cmp;
		logic             err, stepped;
		gds_res_t         r;
		y = int'(cal_year);
		m = int'(cal_month);
		d = int'(cal_day);
		cmp = CMP_EQUAL;
		err = 1'b0;
		stepped = 1'b0;
		case (w.kind)
			KIND_SET: begin
				cal_year  = w.year;
				cal_month = w.month;
				cal_day   = w.day;
			end
			KIND_NEXT_DAY: begin
				d++;
				if (d > month_length(m, y)) begin
					d = int'(DAY_FIRST);
					roll_month_fwd(m, y);
				end
				stepped = 1'b1;
			end
			KIND_PREV_DAY: begin
				d--;
				if (d < int'(DAY_FIRST)) begin
					roll_month_back(m, y);
					len = month_length(m, y);
					d = (len == 0) ? int'(DAY_LONG) : len;
				end
				stepped = 1'b1;
			end
			KIND_NEXT_MONTH: begin
				roll_month_fwd(m, y);
				stepped = 1'b1;
			end
			KIND_PREV_MONTH: begin
				roll_month_back(m, y);
				stepped = 1'b1;
			end
			KIND_COMPARE: begin
				if (cal_year != w.year)
					cmp = (cal_year < w.year) ? CMP_LESS : CMP_GREATER;
				else if (cal_month != w.month)
					cmp = (cal_month < w.month) ? CMP_LESS : CMP_GREATER;
				else if (cal_day != w.day)
					cmp = (cal_day < w.day) ? CMP_LESS : CMP_GREATER;
			end
			default: ;
		endcase

		// Hold the date when a step would carry the year out of range
		if (stepped) begin
			if (y != int'(cal_year) && (y < int'(YEAR_MIN) || y > int'(YEAR_MAX))) begin
				err = 1'b1;
			end else begin
				cal_year  = YEAR_W'(y);
				cal_month = MONTH_W'(m);
				cal_day   = DAY_W'(d);
			end
		end

		r.year        = cal_year;
		r.month       = cal_month;
		r.day         = cal_day;
		r.date_valid  = (cal_day >= DAY_FIRST) &&
		                (int'(cal_day) <= month_length(int'(cal_month), int'(cal_year)));
		r.cmp         = cmp;
		r.range_error = err;
		dates_due.push_back(r);
	endtask

	task automatic queue_word(input logic [KIND_W-1:0] k, input int y, input int m,
	                          input int d);
		date_word_t w;
		w.kind  = k;
		w.year  = YEAR_W'(y);
		w.month = MONTH_W'(m);
		w.day   = DAY_W'(d);
		pending_words.push_back(w);
	endtask

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
			failed_any = 1'b1;
		end
	endtask

	// Drive words in bursts with random gaps; predict each one as it is taken
	always @(posedge clk or negedge arst_n) begin : drive_words
		date_word_t w;
		if (!arst_n) begin
			in_valid <= 1'b0;
			kind     <= '0;
			in_year  <= '0;
			in_month <= '0;
			in_day   <= '0;
		end else begin
			if (in_valid && in_ready) begin
				w.kind  = kind;
				w.year  = in_year;
				w.month = in_month;
				w.day   = in_day;
				advance_calendar(w);
				words_taken++;
			end
			if (!in_valid || in_ready) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (pending_words.size() > 0) begin
					w = pending_words.pop_front();
					kind     <= w.kind;
					in_year  <= w.year;
					in_month <= w.month;
					in_day   <= w.day;
					in_valid <= 1'b1;
					if (burst_left <= 1) begin
						burst_left = $urandom_range(1, 24);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
					end else begin
						burst_left--;
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Stall the output on a randomly chosen pattern, picked anew when its run ends
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (mode_left == 0) begin
				stall_mode = $urandom_range(0, 3);
				mode_left = $urandom_range(8, 64);
			end else begin
				mode_left--;
			end
			case (stall_mode)
				0:       out_ready <= 1'b1;
				1:       out_ready <= 1'($urandom_range(0, 1));
				2:       out_ready <= ($urandom_range(0, 7) == 0);
				default: out_ready <= ~out_ready;
			endcase
		end
	end

	// Check each result word against the oldest prediction
	always @(posedge clk) begin : check_results
		gds_res_t want;
		if (arst_n && out_valid && out_ready) begin
			if (dates_due.size() == 0) begin
				$display("%0t: unexpected result, expected none, got %0d-%0d-%0d", $time,
				         out_year, out_month, out_day);
				failed_any = 1'b1;
			end else begin
				want = dates_due.pop_front();
				check_field("out_year", int'(want.year), int'(out_year));
				check_field("out_month", int'(want.month), int'(out_month));
				check_field("out_day", int'(want.day), int'(out_day));
				check_field("date_valid", int'(want.date_valid), int'(date_valid));
				check_field("compare_result", int'(want.cmp), int'(compare_result));
				check_field("range_error", int'(want.range_error), int'(range_error));
			end
		end
	end

	// Give up on a hung run
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin : stimulus
		int yr, mo, dy, steps, pick;
		bit fwd;

		// Year limits from the reset date, leap rules, out-of-range loads, spare kinds
		queue_word(KIND_COMPARE, 1, 1, 1);
		queue_word(KIND_PREV_DAY, 0, 0, 0);
		queue_word(KIND_PREV_MONTH, 0, 0, 0);
		queue_word(KIND_SET, 9999, 12, 31);
		queue_word(KIND_NEXT_DAY, 0, 0, 0);
		queue_word(KIND_NEXT_MONTH, 0, 0, 0);
		queue_word(KIND_COMPARE, 9998, 12, 31);
		queue_word(KIND_SET, 2000, 2, 28);
		queue_word(KIND_NEXT_DAY, 0, 0, 0);
		queue_word(KIND_NEXT_DAY, 0, 0, 0);
		queue_word(KIND_SET, 1900, 2, 28);
		queue_word(KIND_NEXT_DAY, 0, 0, 0);
		queue_word(KIND_SET, 2024, 3, 1);
		queue_word(KIND_PREV_DAY, 0, 0, 0);
		queue_word(KIND_SET, 2024, 1, 31);
		queue_word(KIND_NEXT_MONTH, 0, 0, 0);
		queue_word(KIND_NEXT_DAY, 0, 0, 0);
		queue_word(KIND_SET, 0, 15, 0);
		queue_word(KIND_NEXT_DAY, 0, 0, 0);
		queue_word(KIND_SET, 5, 0, 0);
		queue_word(KIND_PREV_DAY, 0, 0, 0);
		queue_word(KIND_SET, 100, 14, 1);
		queue_word(KIND_PREV_DAY, 0, 0, 0);
		queue_word(KIND_SET, 16383, 13, 31);
		queue_word(KIND_COMPARE, 16383, 14, 0);
		queue_word(KIND_SPARE_A, 0, 0, 0);
		queue_word(KIND_SPARE_B, 16383, 15, 31);

		// Mostly a load followed by a run of steps, some raw noise in between
		while (pending_words.size() < RANDOM_WORDS) begin
			if ($urandom_range(0, 9) == 0) begin
				queue_word(KIND_W'($urandom_range(0, 7)), $urandom_range(0, 16383),
				           $urandom_range(0, 15), $urandom_range(0, 31));
			end else begin
				pick = $urandom_range(0, 7);
				case (pick)
					0:       yr = $urandom_range(1, 3);
					1:       yr = $urandom_range(9997, 9999);
					2:       yr = 100 * $urandom_range(1, 99);
					3:       yr = 4 * $urandom_range(1, 2499);
					default: yr = $urandom_range(1, 9999);
				endcase
				pick = $urandom_range(0, 3);
				mo = (pick == 0) ? 1 : (pick == 1) ? 12 : $urandom_range(1, 12);
				if ($urandom_range(0, 9) == 0)
					dy = $urandom_range(1, 31);
				else if ($urandom_range(0, 1) == 0)
					dy = $urandom_range(1, month_length(mo, yr));
				else
					dy = ($urandom_range(0, 1) == 0) ? 1 : month_length(mo, yr);
				queue_word(KIND_SET, yr, mo, dy);
				if ($urandom_range(0, 2) == 0)
					queue_word(KIND_COMPARE, yr, mo, dy);
				fwd = 1'($urandom_range(0, 1));
				steps = $urandom_range(3, 30);
				repeat (steps) begin
					pick = $urandom_range(0, 9);
					if (pick < 6)
						queue_word(fwd ? KIND_NEXT_DAY : KIND_PREV_DAY, 0, 0, 0);
					else if (pick < 8)
						queue_word(fwd ? KIND_NEXT_MONTH : KIND_PREV_MONTH, 0, 0, 0);
					else if (pick == 8)
						queue_word(fwd ? KIND_PREV_DAY : KIND_NEXT_DAY, 0, 0, 0);
					else
						queue_word(KIND_COMPARE, (yr + $urandom_range(0, 2) - 1) & 16'h3FFF,
						           $urandom_range(1, 12), $urandom_range(1, 31));
				end
			end
		end
		words_total = pending_words.size();

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Wait for every word to be taken and every result to return
		while (words_taken < words_total || dates_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (!failed_any && dates_due.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
